### hw/rtl/rgc_pkg.sv
// Shared types, constants and control store for the room graph connectivity check.
`timescale 1ns / 1ps

package rgc_pkg;

    localparam int MAX_ROOMS  = 16;
    localparam int DOORS      = 4;
    localparam int SLOT_W     = 4;
    localparam int DOOR_W     = 5;
    localparam int ROW_W      = DOORS * DOOR_W;
    localparam int DEPTH_W    = 5;
    localparam int DOOR_CNT_W = 2;
    localparam int UPC_W      = 3;

    // Jump conditions of a control word.
    typedef enum logic [1:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_EMPTY,
        COND_LAST_DOOR
    } cond_t;

    // One control word of the walk program.
    typedef struct packed {
        logic                   init_walk;
        logic                   pop;
        logic                   load_cur;
        logic                   scan;
        logic                   finish;
        logic                   hold;
        cond_t                  cond;
        logic [UPC_W-1:0]       target;
    } ctrl_t;

    // Status flags fed back to the sequencer.
    typedef struct packed {
        logic stack_empty;
        logic last_door;
    } stat_t;

    localparam logic [UPC_W-1:0] STEP_INIT   = 3'd0;
    localparam logic [UPC_W-1:0] STEP_POP    = 3'd1;
    localparam logic [UPC_W-1:0] STEP_LOAD   = 3'd2;
    localparam logic [UPC_W-1:0] STEP_SCAN   = 3'd3;
    localparam logic [UPC_W-1:0] STEP_FINISH = 3'd4;

    localparam ctrl_t CTRL_NOP = '0;

    // Control store: one word per step.
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
        ctrl_t w;
        w = CTRL_NOP;
        case (upc)
            STEP_INIT:
            begin
                w.init_walk = 1'b1;
            end
            STEP_POP:
            begin
                w.pop    = 1'b1;
                w.cond   = COND_EMPTY;
                w.target = STEP_FINISH;
            end
            STEP_LOAD:
            begin
                w.load_cur = 1'b1;
            end
            STEP_SCAN:
            begin
                w.scan   = 1'b1;
                w.hold   = 1'b1;
                w.cond   = COND_LAST_DOOR;
                w.target = STEP_POP;
            end
            STEP_FINISH:
            begin
                w.finish = 1'b1;
            end
            default:
            begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/rgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/rgc_seq.sv
// Step counter and control store sequencer for the walk program.
`timescale 1ns / 1ps

module rgc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  rgc_pkg::stat_t stat,
    output logic           busy,
    output rgc_pkg::ctrl_t ctrl
);

    logic [rgc_pkg::UPC_W-1:0] upc_reg;
    logic [rgc_pkg::UPC_W-1:0] upc_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= rgc_pkg::STEP_INIT;
            busy_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        ctrl = busy_reg ? rgc_pkg::ucode(upc_reg) : rgc_pkg::CTRL_NOP;
        case (ctrl.cond)
            rgc_pkg::COND_NONE:      taken = 1'b0;
            rgc_pkg::COND_ALWAYS:    taken = 1'b1;
            rgc_pkg::COND_EMPTY:     taken = stat.stack_empty;
            rgc_pkg::COND_LAST_DOOR: taken = stat.last_door;
            default:                 taken = 1'b0;
        endcase

        upc_next  = upc_reg;
        busy_next = busy_reg;
        if (go)
        begin
            upc_next  = rgc_pkg::STEP_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ctrl.finish)
            begin
                busy_next = 1'b0;
            end
            else if (taken)
            begin
                upc_next = ctrl.target;
            end
            else if (!ctrl.hold)
            begin
                upc_next = upc_reg + 1'b1;
            end
        end
    end

    assign busy = busy_reg;

endmodule

### hw/rtl/rgc_dp.sv
// Datapath: room table flags, visited set, stack pointer and result registers.
`timescale 1ns / 1ps

module rgc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [rgc_pkg::SLOT_W-1:0]         room_index,
    input  logic                               is_room,
    input  logic [rgc_pkg::ROW_W-1:0]          door_row,
    input  rgc_pkg::ctrl_t                     ctrl,
    output rgc_pkg::stat_t                     stat,
    output logic                               door_we,
    output logic [rgc_pkg::SLOT_W-1:0]         door_waddr,
    output logic [rgc_pkg::ROW_W-1:0]          door_wdata,
    output logic                               door_re,
    output logic [rgc_pkg::SLOT_W-1:0]         door_raddr,
    input  logic [rgc_pkg::ROW_W-1:0]          door_rdata,
    output logic                               st_we,
    output logic [rgc_pkg::SLOT_W-1:0]         st_waddr,
    output logic [rgc_pkg::SLOT_W-1:0]         st_wdata,
    output logic                               st_re,
    output logic [rgc_pkg::SLOT_W-1:0]         st_raddr,
    input  logic [rgc_pkg::SLOT_W-1:0]         st_rdata,
    output logic                               done,
    output logic                               all_connected,
    output logic [rgc_pkg::MAX_ROOMS-1:0]      reached_mask,
    output logic [rgc_pkg::SLOT_W-1:0]         start_room
);

    logic [rgc_pkg::MAX_ROOMS-1:0]  room_kind_reg, room_kind_next;
    logic [rgc_pkg::MAX_ROOMS-1:0]  row_valid_reg, row_valid_next;
    logic [rgc_pkg::MAX_ROOMS-1:0]  visited_reg, visited_next;
    logic [rgc_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic                           done_reg, done_next;
    logic [rgc_pkg::SLOT_W-1:0]     cur_reg, cur_next;
    logic [rgc_pkg::DOOR_CNT_W-1:0] door_cnt_reg, door_cnt_next;
    logic [rgc_pkg::SLOT_W-1:0]     start_reg, start_next;
    logic                           ok_reg, ok_next;
    logic [rgc_pkg::MAX_ROOMS-1:0]  mask_reg, mask_next;
    logic [rgc_pkg::SLOT_W-1:0]     start_slot;
    logic [rgc_pkg::DOOR_W-1:0]     door_t;
    logic [rgc_pkg::SLOT_W-1:0]     target;
    logic                           door_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_kind_reg <= '0;
            row_valid_reg <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            room_kind_reg <= room_kind_next;
            row_valid_reg <= row_valid_next;
            visited_reg   <= visited_next;
            depth_reg     <= depth_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        door_cnt_reg <= door_cnt_next;
        start_reg    <= start_next;
        ok_reg       <= ok_next;
        mask_reg     <= mask_next;
    end

    // Highest real room, slot 0 when there is none.
    always_comb
    begin
        start_slot = '0;
        for (int i = 0; i < rgc_pkg::MAX_ROOMS; i++)
        begin
            if (room_kind_reg[i])
            begin
                start_slot = i[rgc_pkg::SLOT_W-1:0];
            end
        end
    end

    // A row never written since the last clear reads as all doors absent.
    assign door_t  = door_rdata[door_cnt_reg*rgc_pkg::DOOR_W +: rgc_pkg::DOOR_W];
    assign target  = door_t[rgc_pkg::SLOT_W-1:0];
    assign door_ok = row_valid_reg[cur_reg] && !door_t[rgc_pkg::DOOR_W-1]
                     && !visited_reg[target];

    always_comb
    begin
        room_kind_next = room_kind_reg;
        row_valid_next = row_valid_reg;
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        done_next      = 1'b0;
        cur_next       = cur_reg;
        door_cnt_next  = door_cnt_reg;
        start_next     = start_reg;
        ok_next        = ok_reg;
        mask_next      = mask_reg;

        door_we    = load;
        door_waddr = room_index;
        door_wdata = door_row;
        door_re    = ctrl.load_cur;
        door_raddr = st_rdata;
        st_we      = 1'b0;
        st_waddr   = depth_reg[rgc_pkg::SLOT_W-1:0];
        st_wdata   = target;
        st_re      = 1'b0;
        st_raddr   = st_waddr - 1'b1;

        if (load)
        begin
            room_kind_next[room_index] = is_room;
            row_valid_next[room_index] = 1'b1;
        end

        if (ctrl.init_walk)
        begin
            visited_next             = '0;
            visited_next[start_slot] = 1'b1;
            start_next               = start_slot;
            st_we                    = 1'b1;
            st_waddr                 = '0;
            st_wdata                 = start_slot;
            depth_next               = rgc_pkg::DEPTH_W'(1);
        end

        if (ctrl.pop && depth_reg != '0)
        begin
            st_re      = 1'b1;
            depth_next = depth_reg - 1'b1;
        end

        if (ctrl.load_cur)
        begin
            cur_next      = st_rdata;
            door_cnt_next = '0;
        end

        if (ctrl.scan)
        begin
            door_cnt_next = door_cnt_reg + 1'b1;
            if (door_ok)
            begin
                visited_next[target] = 1'b1;
                if (depth_reg < rgc_pkg::DEPTH_W'(rgc_pkg::MAX_ROOMS))
                begin
                    st_we      = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
        end

        if (ctrl.finish)
        begin
            done_next      = 1'b1;
            ok_next        = ~|(room_kind_reg & ~visited_reg);
            mask_next      = visited_reg;
            room_kind_next = '0;
            row_valid_next = '0;
        end
    end

    assign stat.stack_empty = (depth_reg == '0);
    assign stat.last_door   = (door_cnt_reg == rgc_pkg::DOOR_CNT_W'(rgc_pkg::DOORS - 1));

    assign done          = done_reg;
    assign all_connected = ok_reg;
    assign reached_mask  = mask_reg;
    assign start_room    = start_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= rgc_pkg::DEPTH_W'(rgc_pkg::MAX_ROOMS))
        else $error("walk stack depth beyond table size");

    a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.init_walk |=> visited_reg[start_reg])
        else $error("start slot not marked visited");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_cur |-> $past(st_re))
        else $error("slot loaded without a stack read");

endmodule

### hw/rtl/room_graph_connectivity_check.sv
// Top level of the room graph connectivity check: sequencer, datapath and two RAMs.
`timescale 1ns / 1ps

// Records load one per cycle while busy is low; a record without last gives no result.
// A record with last starts the walk: an init step, then for each slot reached a pop,
// a load of the slot and one step per door, then a final pop and a finish step; done
// is registered from the finish step.
// done lasts one cycle and cannot be stalled; busy is already low in that cycle.
// Reset (async, rst_n low) empties the room table and idles the sequencer.
module room_graph_connectivity_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rgc_pkg::SLOT_W-1:0]    room_index,
    input  logic                          is_room,
    input  logic signed [rgc_pkg::DOOR_W-1:0] door_a,
    input  logic signed [rgc_pkg::DOOR_W-1:0] door_b,
    input  logic signed [rgc_pkg::DOOR_W-1:0] door_c,
    input  logic signed [rgc_pkg::DOOR_W-1:0] door_d,
    input  logic                          last,
    output logic                          done,
    output logic                          all_connected,
    output logic [rgc_pkg::MAX_ROOMS-1:0] reached_mask,
    output logic [rgc_pkg::SLOT_W-1:0]    start_room
);

    logic                          load;
    logic                          go;
    rgc_pkg::ctrl_t                ctrl;
    rgc_pkg::stat_t                stat;
    logic [rgc_pkg::ROW_W-1:0]     door_row;
    logic                          door_we;
    logic [rgc_pkg::SLOT_W-1:0]    door_waddr;
    logic [rgc_pkg::ROW_W-1:0]     door_wdata;
    logic                          door_re;
    logic [rgc_pkg::SLOT_W-1:0]    door_raddr;
    logic [rgc_pkg::ROW_W-1:0]     door_rdata;
    logic                          st_we;
    logic [rgc_pkg::SLOT_W-1:0]    st_waddr;
    logic [rgc_pkg::SLOT_W-1:0]    st_wdata;
    logic                          st_re;
    logic [rgc_pkg::SLOT_W-1:0]    st_raddr;
    logic [rgc_pkg::SLOT_W-1:0]    st_rdata;

    // Every transfer stores its record; only a last record kicks off the walk.
    assign load = start && !busy;
    assign go   = load && last;

    // Pack the four doors into one table row, first door in the low bits.
    assign door_row = {door_d, door_c, door_b, door_a};

    rgc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    rgc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .room_index    (room_index),
        .is_room       (is_room),
        .door_row      (door_row),
        .ctrl          (ctrl),
        .stat          (stat),
        .door_we       (door_we),
        .door_waddr    (door_waddr),
        .door_wdata    (door_wdata),
        .door_re       (door_re),
        .door_raddr    (door_raddr),
        .door_rdata    (door_rdata),
        .st_we         (st_we),
        .st_waddr      (st_waddr),
        .st_wdata      (st_wdata),
        .st_re         (st_re),
        .st_raddr      (st_raddr),
        .st_rdata      (st_rdata),
        .done          (done),
        .all_connected (all_connected),
        .reached_mask  (reached_mask),
        .start_room    (start_room)
    );

    // Door table: one row of door links per slot; row valid bits live in the datapath.
    rgc_ram #(
        .WIDTH (rgc_pkg::ROW_W),
        .DEPTH (rgc_pkg::MAX_ROOMS)
    ) u_door_ram (
        .clk   (clk),
        .we    (door_we),
        .waddr (door_waddr),
        .wdata (door_wdata),
        .re    (door_re),
        .raddr (door_raddr),
        .rdata (door_rdata)
    );

    // Walk stack: each slot is pushed at most once, so the table depth suffices.
    rgc_ram #(
        .WIDTH (rgc_pkg::SLOT_W),
        .DEPTH (rgc_pkg::MAX_ROOMS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the walk still runs");

    a_start_reached: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> reached_mask[start_room])
        else $error("start slot missing from reached mask");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && last))
        else $error("walk began without a last record");

endmodule
